@@ rtl/core/tesp_pkg.sv @@
// shared types and constants for the tlb entry store and probe block
`default_nettype none

package tesp_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int IDX_MAX_W   = 6;
  localparam int TAG_W       = 40;
  localparam int PAGE_W      = 58;
  localparam int VPN_W       = 19;
  localparam int ASID_W      = 8;
  localparam int MASK_W      = 12;
  localparam int SEL_W       = 5;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_RANDOM = 2'd2,
    CMD_PROBE  = 2'd3
  } cmd_t;

  // request travelling down the row of entry cells
  typedef struct packed {
    logic                  valid;
    logic                  is_read;
    logic                  is_probe;
    logic [SEL_W-1:0]      sel;
    logic [VPN_W-1:0]      key;
    logic [ASID_W-1:0]     asid;
    logic                  hit;
    logic [IDX_MAX_W-1:0]  hit_idx;
    logic [TAG_W-1:0]      rd_tag;
    logic [PAGE_W-1:0]     rd_page;
  } tesp_msg_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic                  en;
    logic [IDX_MAX_W-1:0]  idx;
    logic [TAG_W-1:0]      tag;
    logic [PAGE_W-1:0]     page;
  } tesp_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/tesp_cell.sv @@
// one tlb entry cell: holds an entry, matches and forwards the passing request
`default_nettype none

module tesp_cell import tesp_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  tesp_wr_t  wr,
  input  tesp_msg_t msg_in,
  output tesp_msg_t msg_out
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_ID);

  logic [TAG_W-1:0]  tag;
  logic [PAGE_W-1:0] page;
  logic [MASK_W-1:0] mask;
  logic [VPN_W-1:0]  vpn;
  logic [ASID_W-1:0] asid;
  logic              glob;
  logic              match;
  tesp_msg_t         msg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag  <= '0;
      page <= '0;
    end else if (wr.en && wr.idx == MY_IDX) begin
      tag  <= wr.tag;
      page <= wr.page;
    end
  end

  assign mask = tag[39:28];
  assign vpn  = tag[27:9];
  assign asid = tag[8:1];
  assign glob = tag[0];

  // vpn2 compare outside the page mask, asid compare unless global
  assign match = (((vpn ^ msg_in.key) & ~{{(VPN_W-MASK_W){1'b0}}, mask}) == '0) &&
                 (glob || asid == msg_in.asid);

  always_comb begin
    msg_next = msg_in;
    if (msg_in.valid && msg_in.is_probe && !msg_in.hit && match) begin
      msg_next.hit     = 1'b1;
      msg_next.hit_idx = MY_IDX;
    end
    if (msg_in.valid && msg_in.is_read && {1'b0, msg_in.sel} == MY_IDX) begin
      msg_next.rd_tag  = tag;
      msg_next.rd_page = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_out <= '0;
    end else begin
      msg_out <= msg_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tesp_div.sv @@
// bit-serial restoring remainder unit for the random replacement choice
`default_nettype none

module tesp_div import tesp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [5:0]  divisor,
  output logic        done,
  output logic [5:0]  rem
);

  logic [30:0] dvd;
  logic [4:0]  cnt;
  logic        busy;
  logic [6:0]  trial;
  logic [6:0]  diff;

  assign trial = {rem, dvd[30]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      cnt <= 5'd30;
    end else if (busy) begin
      dvd <= {dvd[29:0], 1'b0};
      cnt <= cnt - 5'd1;
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[5:0];
      end else begin
        rem <= trial[5:0];
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/core/tlb_entry_store_probe.sv @@
// top level of the tlb entry store: command control, entry cell row, random pick
`default_nettype none

// read and probe: a request walks the row of ENTRIES cells, one cell per cycle,
//   and the result strobe is registered once the request leaves the last cell
// write indexed: result through the S_WRITE state; write random: S_DIV waits on
//   the 31-step bit-serial remainder unit, then S_WRITE; busy stays high until the result
// one request at a time; results cannot be stalled and show for one cycle
// synchronous reset clears all entries to zero and wired_entries to zero
module tlb_entry_store_probe import tesp_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: wired_entries
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] index_reg,
  input  logic [31:0] entry_hi,
  input  logic [31:0] entry_lo_even,
  input  logic [31:0] entry_lo_odd,
  input  logic [31:0] page_mask,
  input  logic [31:0] cycle_count,
  // result side
  output logic        done,
  output logic [24:0] page_mask_out,
  output logic [31:0] entry_hi_out,
  output logic [29:0] entry_lo_even_out,
  output logic [29:0] entry_lo_odd_out,
  output logic [31:0] index_out,
  output logic [4:0]  random_out
);

  localparam logic [6:0] ENTRIES_V = 7'(ENTRIES);
  localparam logic [4:0] LAST_PICK = 5'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DIV   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [4:0]  wired;
  logic        accept;

  // latched request
  logic [1:0]  cmd_q;
  logic [31:0] idx_q;
  logic [31:0] hi_q;
  logic [31:0] lo0_q;
  logic [31:0] lo1_q;
  logic [31:0] pm_q;
  logic [4:0]  pick_q;
  logic        inj_valid;

  // random pick
  logic        div_done;
  logic [5:0]  div_rem;
  logic [5:0]  divisor;
  logic [4:0]  pick_sum;
  logic [4:0]  pick_next;

  // cell row
  tesp_msg_t   chain [ENTRIES+1];
  tesp_wr_t    wr;
  tesp_msg_t   tail;

  function automatic logic [28:0] pack_page(input logic [31:0] lo);
    pack_page = {lo[29:6], lo[5:3], lo[2], lo[1]};
  endfunction

  function automatic logic [29:0] unpack_page(input logic [28:0] p, input logic g);
    unpack_page = {p[28:5], p[4:2], p[1], p[0], g};
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // wired register
  always_ff @(posedge clk) begin
    if (rst) begin
      wired <= '0;
    end else if (cfg_we) begin
      wired <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      idx_q <= index_reg;
      hi_q  <= entry_hi;
      lo0_q <= entry_lo_even;
      lo1_q <= entry_lo_odd;
      pm_q  <= page_mask;
    end
  end

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_READ, CMD_PROBE: state_next = S_WALK;
            CMD_RANDOM:          state_next = S_DIV;
            default:             state_next = S_WRITE;
          endcase
        end
      end
      S_WALK: begin
        if (tail.valid) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inj_valid <= 1'b0;
    end else begin
      state     <= state_next;
      inj_valid <= accept && (cmd == CMD_READ || cmd == CMD_PROBE);
    end
  end

  // random choice: (count / 2 mod (32 - wired)) + wired, clipped to the store
  assign divisor  = 6'd32 - {1'b0, wired};
  assign pick_sum = div_rem[4:0] + wired;

  always_comb begin
    if ({2'b0, wired} >= ENTRIES_V) begin
      pick_next = LAST_PICK;
    end else if ({2'b0, pick_sum} >= ENTRIES_V) begin
      pick_next = LAST_PICK;
    end else begin
      pick_next = pick_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      pick_q <= pick_next;
    end
  end

  tesp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && cmd == CMD_RANDOM),
    .dividend (cycle_count[31:1]),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // entry write, broadcast to every cell; only index bits 4:0 are used, and an index past the store there hits no cell
  always_comb begin
    wr.en   = (state == S_WRITE);
    wr.idx  = (cmd_q == CMD_RANDOM) ? {1'b0, pick_q} : {1'b0, idx_q[4:0]};
    wr.tag  = {pm_q[24:13], hi_q[31:13], hi_q[7:0], lo0_q[0] & lo1_q[0]};
    wr.page = {pack_page(lo1_q), pack_page(lo0_q)};
  end

  // request injected at the head of the cell row
  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = inj_valid;
    chain[0].is_read  = (cmd_q == CMD_READ);
    chain[0].is_probe = (cmd_q == CMD_PROBE);
    chain[0].sel      = idx_q[4:0];
    chain[0].key      = hi_q[31:13];
    chain[0].asid     = hi_q[7:0];
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tesp_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .msg_in  (chain[i]),
      .msg_out (chain[i+1])
    );
  end

  assign tail = chain[ENTRIES];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_WALK && tail.valid) || (state == S_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK && tail.valid) begin
      random_out <= '0;
      if (cmd_q == CMD_READ) begin
        // a read whose index bits 4:0 name no cell returns the entry fields as all zero
        page_mask_out     <= {tail.rd_tag[39:28], 13'b0};
        entry_hi_out      <= {tail.rd_tag[27:9], 5'b0, tail.rd_tag[8:1]};
        entry_lo_even_out <= unpack_page(tail.rd_page[28:0], tail.rd_tag[0]);
        entry_lo_odd_out  <= unpack_page(tail.rd_page[57:29], tail.rd_tag[0]);
        index_out         <= idx_q;
      end else begin
        page_mask_out     <= '0;
        entry_hi_out      <= '0;
        entry_lo_even_out <= '0;
        entry_lo_odd_out  <= '0;
        // probe miss keeps the index with the top bit set
        index_out         <= tail.hit ? {{(32-IDX_MAX_W){1'b0}}, tail.hit_idx}
                                      : (idx_q | 32'h8000_0000);
      end
    end else if (state == S_WRITE) begin
      page_mask_out     <= '0;
      entry_hi_out      <= '0;
      entry_lo_even_out <= '0;
      entry_lo_odd_out  <= '0;
      index_out         <= idx_q;
      random_out        <= (cmd_q == CMD_RANDOM) ? pick_q : '0;
    end
  end

  // a result strobe only closes a request in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without a request");

  // every entry write is followed by its result
  a_write_then_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> done)
    else $error("write without result");

  // the walk only reaches the end of the row while a walk is in progress
  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == S_WALK)
    else $error("stray request at end of cell row");

  // the random pick always lands inside the store
  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && cmd_q == CMD_RANDOM) |-> {2'b0, pick_q} < ENTRIES_V)
    else $error("random pick outside the store");

endmodule

`default_nettype wire
